// File: rtl/tspl_pkg.sv
// Shared types and constants of the track strip point locator.
`default_nettype none

package tspl_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_POINTS_DEF  = 256;
  localparam int COORD_BITS_DEF  = 16;

  // Fixed field widths.
  localparam int INDEX_W = 8;
  localparam int PLACE_W = 8;
  localparam int COUNT_W = 9;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd3;
  localparam logic [COUNT_W-1:0] COUNT_MIN   = 9'd3;

  // Command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Edge selection codes. The edges of one segment's two triangles, with
  // I and O the inner and outer points, i the segment start, j its end.
  typedef logic [2:0] edge_tag_t;
  localparam edge_tag_t EDGE_OI_II = 3'd0;
  localparam edge_tag_t EDGE_II_IJ = 3'd1;
  localparam edge_tag_t EDGE_IJ_OI = 3'd2;
  localparam edge_tag_t EDGE_IJ_OJ = 3'd3;
  localparam edge_tag_t EDGE_OJ_OI = 3'd4;
  localparam edge_tag_t EDGE_LAST  = EDGE_OJ_OI;
  localparam int        EDGE_CNT   = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_NEXT,
    ST_EDGE,
    ST_DRAIN,
    ST_EVAL
  } state_t;

  // Request into the shared edge-function unit.
  typedef struct packed {
    logic      valid;
    edge_tag_t tag;
  } edge_req_t;

  // Sign of one edge function coming out of the unit.
  typedef struct packed {
    logic      valid;
    edge_tag_t tag;
    logic      neg;
    logic      pos;
  } edge_res_t;

endpackage

`default_nettype wire

// File: rtl/tspl_point_mem.sv
// Point pair table: one write port, one registered read port.
`default_nettype none

module tspl_point_mem #(
  parameter int MAX_POINTS = tspl_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = tspl_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(MAX_POINTS)-1:0] wr_addr,
  input  wire logic [4*COORD_BITS-1:0]       wr_data,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  output logic      [4*COORD_BITS-1:0]       rd_data
);

  logic [4*COORD_BITS-1:0] mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/tspl_edge_unit.sv
// Pipelined edge-function unit: sign of (px-bx)*(az-bz) - (ax-bx)*(pz-bz).
`default_nettype none

module tspl_edge_unit #(
  parameter int COORD_BITS = tspl_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tspl_pkg::edge_req_t           req,
  input  wire logic signed [COORD_BITS-1:0]  px,
  input  wire logic signed [COORD_BITS-1:0]  pz,
  input  wire logic signed [COORD_BITS-1:0]  ax,
  input  wire logic signed [COORD_BITS-1:0]  az,
  input  wire logic signed [COORD_BITS-1:0]  bx,
  input  wire logic signed [COORD_BITS-1:0]  bz,
  output tspl_pkg::edge_res_t                res
);

  localparam int DW = COORD_BITS + 1;
  localparam int MW = 2 * DW;
  localparam int SW = MW + 1;

  logic signed [DW-1:0] d_px, d_az, d_ax, d_pz;
  logic signed [MW-1:0] m_left, m_right;
  logic        [SW-1:0] diff;
  logic                 v1, v2;
  tspl_pkg::edge_tag_t  tag1, tag2;

  assign diff = {m_left[MW-1], m_left} - {m_right[MW-1], m_right};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      v1        <= req.valid;
      v2        <= v1;
      res.valid <= v2;
    end
    res.tag <= tag2;
    res.neg <= diff[SW-1];
    res.pos <= !diff[SW-1] && (diff != '0);
  end

  always_ff @(posedge clk) begin
    // Differences are one bit wider than the coordinates, so all is exact.
    d_px    <= {px[COORD_BITS-1], px} - {bx[COORD_BITS-1], bx};
    d_az    <= {az[COORD_BITS-1], az} - {bz[COORD_BITS-1], bz};
    d_ax    <= {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
    d_pz    <= {pz[COORD_BITS-1], pz} - {bz[COORD_BITS-1], bz};
    tag1    <= req.tag;
    m_left  <= d_px * d_az;
    m_right <= d_ax * d_pz;
    tag2    <= tag1;
  end

endmodule

`default_nettype wire

// File: rtl/tspl_ctrl.sv
// Sequencer: walks the segments, feeds the edge unit and forms the result.
`default_nettype none

module tspl_ctrl #(
  parameter int MAX_POINTS = tspl_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = tspl_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic                                cmd,
  input  wire logic [tspl_pkg::INDEX_W-1:0]        entry_index,
  input  wire logic [tspl_pkg::COUNT_W-1:0]        point_count,
  input  wire logic signed [COORD_BITS-1:0]        query_x,
  input  wire logic signed [COORD_BITS-1:0]        query_z,
  output logic                                     busy,
  output logic                                     wr_en,
  output logic [$clog2(MAX_POINTS)-1:0]            wr_addr,
  output logic                                     rd_en,
  output logic [$clog2(MAX_POINTS)-1:0]            rd_addr,
  input  wire logic [4*COORD_BITS-1:0]             rd_data,
  output tspl_pkg::edge_req_t                      edge_req,
  output logic signed [COORD_BITS-1:0]             px,
  output logic signed [COORD_BITS-1:0]             pz,
  output logic signed [COORD_BITS-1:0]             ax,
  output logic signed [COORD_BITS-1:0]             az,
  output logic signed [COORD_BITS-1:0]             bx,
  output logic signed [COORD_BITS-1:0]             bz,
  input  wire tspl_pkg::edge_res_t                 edge_res,
  output logic                                     result_valid,
  output logic [tspl_pkg::PLACE_W-1:0]             place_index,
  output logic                                     on_track
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = COORD_BITS;
  localparam int EW = IW + tspl_pkg::INDEX_W;
  localparam int PW = IW + tspl_pkg::PLACE_W;

  tspl_pkg::state_t    state, state_next;
  tspl_pkg::edge_tag_t k;

  logic [IW-1:0]   seg, seg_succ, last_seg, last_next;
  logic [4*CW-1:0] cur;
  logic [EW-1:0]   entry_wide;
  logic [PW-1:0]   seg_wide;
  logic            accept, query_go, in_range, hit, done;
  logic            tri_a, tri_b;
  logic            neg_flags [tspl_pkg::EDGE_CNT];
  logic            pos_flags [tspl_pkg::EDGE_CNT];

  logic signed [CW-1:0] ci_x, ci_z, co_x, co_z, ni_x, ni_z, no_x, no_z;
  logic signed [CW-1:0] cur_px_q, cur_pz_q;

  assign ci_x = cur[4*CW-1:3*CW];
  assign ci_z = cur[3*CW-1:2*CW];
  assign co_x = cur[2*CW-1:CW];
  assign co_z = cur[CW-1:0];
  // The end pair of the segment stays on the read port while edges issue.
  assign ni_x = rd_data[4*CW-1:3*CW];
  assign ni_z = rd_data[3*CW-1:2*CW];
  assign no_x = rd_data[2*CW-1:CW];
  assign no_z = rd_data[CW-1:0];

  assign accept   = start && !busy;
  assign query_go = accept && (cmd == tspl_pkg::CMD_QUERY);

  assign entry_wide = {{IW{1'b0}}, entry_index};
  assign in_range   = entry_wide < EW'(MAX_POINTS);
  assign wr_addr    = entry_wide[IW-1:0];
  assign wr_en      = accept && (cmd == tspl_pkg::CMD_LOAD) && in_range;

  always_comb begin
    if (point_count < tspl_pkg::COUNT_MIN) begin
      last_next = IW'(tspl_pkg::COUNT_MIN - 9'd1);
    end else if (32'(point_count) > MAX_POINTS) begin
      last_next = IW'(MAX_POINTS - 1);
    end else begin
      last_next = IW'(point_count - 9'd1);
    end
  end

  // The segment after the last one closes the track back to pair 0.
  assign seg_succ = (seg == last_seg) ? '0 : seg + IW'(1);
  assign seg_wide = {{tspl_pkg::PLACE_W{1'b0}}, seg};

  // The second triangle's edge from OI to IJ is the first triangle's edge
  // from IJ to OI reversed, so its signs are swapped instead of recomputed.
  assign tri_a = !((neg_flags[0] || neg_flags[1] || neg_flags[2]) &&
                   (pos_flags[0] || pos_flags[1] || pos_flags[2]));
  assign tri_b = !((pos_flags[2] || neg_flags[3] || neg_flags[4]) &&
                   (neg_flags[2] || pos_flags[3] || pos_flags[4]));
  assign hit   = tri_a || tri_b;
  assign done  = hit || (seg == last_seg);

  assign px = cur_px_q;
  assign pz = cur_pz_q;

  always_comb begin
    case (k)
      tspl_pkg::EDGE_OI_II: begin
        ax = co_x; az = co_z; bx = ci_x; bz = ci_z;
      end
      tspl_pkg::EDGE_II_IJ: begin
        ax = ci_x; az = ci_z; bx = ni_x; bz = ni_z;
      end
      tspl_pkg::EDGE_IJ_OI: begin
        ax = ni_x; az = ni_z; bx = co_x; bz = co_z;
      end
      tspl_pkg::EDGE_IJ_OJ: begin
        ax = ni_x; az = ni_z; bx = no_x; bz = no_z;
      end
      tspl_pkg::EDGE_OJ_OI: begin
        ax = no_x; az = no_z; bx = co_x; bz = co_z;
      end
      default: begin
        ax = co_x; az = co_z; bx = ci_x; bz = ci_z;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      tspl_pkg::ST_IDLE: begin
        if (query_go) begin
          state_next = tspl_pkg::ST_FIRST;
        end
      end
      tspl_pkg::ST_FIRST: begin
        state_next = tspl_pkg::ST_NEXT;
      end
      tspl_pkg::ST_NEXT: begin
        state_next = tspl_pkg::ST_EDGE;
      end
      tspl_pkg::ST_EDGE: begin
        if (k == tspl_pkg::EDGE_LAST) begin
          state_next = tspl_pkg::ST_DRAIN;
        end
      end
      tspl_pkg::ST_DRAIN: begin
        if (edge_res.valid && (edge_res.tag == tspl_pkg::EDGE_LAST)) begin
          state_next = tspl_pkg::ST_EVAL;
        end
      end
      tspl_pkg::ST_EVAL: begin
        state_next = done ? tspl_pkg::ST_IDLE : tspl_pkg::ST_NEXT;
      end
      default: begin
        state_next = tspl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy           = 1'b1;
    rd_en          = 1'b0;
    rd_addr        = seg_succ;
    edge_req.valid = 1'b0;
    edge_req.tag   = k;
    case (state)
      tspl_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      tspl_pkg::ST_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      tspl_pkg::ST_NEXT: begin
        rd_en = 1'b1;
      end
      tspl_pkg::ST_EDGE: begin
        edge_req.valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tspl_pkg::ST_IDLE;
      k            <= tspl_pkg::EDGE_OI_II;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == tspl_pkg::ST_EVAL) && done;
      if (state == tspl_pkg::ST_EDGE) begin
        k <= k + 3'd1;
      end else begin
        k <= tspl_pkg::EDGE_OI_II;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_go) begin
      cur_px_q <= query_x;
      cur_pz_q <= query_z;
      last_seg <= last_next;
      seg      <= '0;
    end
    // Pair 0 arrives while the first segment's end pair is being read.
    if ((state == tspl_pkg::ST_NEXT) && (seg == '0)) begin
      cur <= rd_data;
    end
    if (edge_res.valid) begin
      neg_flags[edge_res.tag] <= edge_res.neg;
      pos_flags[edge_res.tag] <= edge_res.pos;
    end
    if (state == tspl_pkg::ST_EVAL) begin
      cur         <= rd_data;
      place_index <= seg_wide[tspl_pkg::PLACE_W-1:0];
      on_track    <= hit;
      if (!done) begin
        seg <= seg_succ;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/track_strip_point_locator.sv
// Top level of the track strip point locator.
`default_nettype none

// A load (cmd 0) writes one inner/outer point pair in the cycle it is taken
// and leaves busy low; it gives no result. A query (cmd 1) walks the segments
// in order, testing each segment's two triangles through one shared
// edge-function unit that is fed one edge per cycle and has three stages.
// Each segment takes a read of its end pair, the issue of its edges, a drain of
// the pipeline and an evaluation. The walk stops at the first segment that
// holds the point or after segment n-1, where n is the point count
// clamped to the range 3 to MAX_POINTS.
// The result is on place_index and on_track for the single cycle in which
// result_valid is high, the first cycle with busy low again, and cannot be
// held off; a new command may be taken in that same cycle. The point count
// register is written through cfg_valid/cfg_data, is always ready and should
// only be written while the block is not busy.
module track_strip_point_locator #(
  parameter int MAX_POINTS = tspl_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = tspl_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cmd,
  input  wire logic [tspl_pkg::INDEX_W-1:0]  entry_index,
  input  wire logic signed [COORD_BITS-1:0]  inner_x,
  input  wire logic signed [COORD_BITS-1:0]  inner_z,
  input  wire logic signed [COORD_BITS-1:0]  outer_x,
  input  wire logic signed [COORD_BITS-1:0]  outer_z,
  input  wire logic signed [COORD_BITS-1:0]  query_x,
  input  wire logic signed [COORD_BITS-1:0]  query_z,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tspl_pkg::COUNT_W-1:0]  cfg_data,
  output logic                               result_valid,
  output logic [tspl_pkg::PLACE_W-1:0]       place_index,
  output logic                               on_track
);

  localparam int IW = $clog2(MAX_POINTS);

  logic [tspl_pkg::COUNT_W-1:0] point_count;
  logic                         wr_en, rd_en;
  logic [IW-1:0]                wr_addr, rd_addr;
  logic [4*COORD_BITS-1:0]      rd_data;
  tspl_pkg::edge_req_t          edge_req;
  tspl_pkg::edge_res_t          edge_res;
  logic signed [COORD_BITS-1:0] px, pz, ax, az, bx, bz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= tspl_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      point_count <= cfg_data;
    end
  end

  tspl_point_mem #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({inner_x, inner_z, outer_x, outer_z}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tspl_edge_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_edge (
    .clk (clk),
    .rst (rst),
    .req (edge_req),
    .px  (px),
    .pz  (pz),
    .ax  (ax),
    .az  (az),
    .bx  (bx),
    .bz  (bz),
    .res (edge_res)
  );

  tspl_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .entry_index  (entry_index),
    .point_count  (point_count),
    .query_x      (query_x),
    .query_z      (query_z),
    .busy         (busy),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .edge_req     (edge_req),
    .px           (px),
    .pz           (pz),
    .ax           (ax),
    .az           (az),
    .bx           (bx),
    .bz           (bz),
    .edge_res     (edge_res),
    .result_valid (result_valid),
    .place_index  (place_index),
    .on_track     (on_track)
  );

`ifndef SYNTHESIS
  // A result only ever closes a query that was in progress.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe without a query in progress");

  // One query yields a single one-cycle result.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == tspl_pkg::CMD_QUERY)) |=> busy)
    else $error("accepted query did not start the segment walk");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == tspl_pkg::CMD_LOAD)) |=> !busy)
    else $error("load transaction made the block busy");
`endif

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the track strip point locator: tracks, queries and point counts.
module tb_top;

  localparam int PTS         = tspl_pkg::MAX_POINTS_DEF;
  localparam int CW          = tspl_pkg::COORD_BITS_DEF;
  localparam int ITEM_TARGET = 1950;

  typedef struct {
    logic                          cmd;
    logic [tspl_pkg::INDEX_W-1:0]  idx;
    logic signed [CW-1:0]          ix, iz, ox, oz, qx, qz;
  } track_cmd_t;

  typedef struct {
    logic [tspl_pkg::PLACE_W-1:0] place;
    logic                         on_trk;
  } locate_t;

  // Keeps its own copy of the point table and count, predicts every query and
  // checks the results in order.
  class track_scoreboard;
    logic signed [CW-1:0]         in_x[PTS], in_z[PTS], out_x[PTS], out_z[PTS];
    bit                           loaded[PTS];
    logic [tspl_pkg::COUNT_W-1:0] count;
    locate_t                      pending[$];
    int                           errors;

    function new();
      count = tspl_pkg::COUNT_RESET;
      errors = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    task report_mismatch(string msg);
      if (errors < 100) $display("%0t ERROR: %s", $time, msg);
      errors++;
    endtask

    function int eff_count();
      if (count < tspl_pkg::COUNT_MIN) return int'(tspl_pkg::COUNT_MIN);
      if (count > PTS) return PTS;
      return int'(count);
    endfunction

    function void set_count(logic [tspl_pkg::COUNT_W-1:0] v);
      count = v;
    endfunction

    function int edge_sign(longint px, longint pz, longint ax, longint az,
                           longint bx, longint bz);
      longint d;
      d = (px - bx) * (az - bz) - (ax - bx) * (pz - bz);
      return (d < 0) ? -1 : ((d > 0) ? 1 : 0);
    endfunction

    // Points on an edge count as inside, and either winding works.
    function bit tri_holds(longint px, longint pz, longint ax, longint az,
                           longint bx, longint bz, longint cx, longint cz);
      int s1, s2, s3;
      s1 = edge_sign(px, pz, ax, az, bx, bz);
      s2 = edge_sign(px, pz, bx, bz, cx, cz);
      s3 = edge_sign(px, pz, cx, cz, ax, az);
      return !((s1 < 0 || s2 < 0 || s3 < 0) && (s1 > 0 || s2 > 0 || s3 > 0));
    endfunction

    function bit seg_holds(longint px, longint pz, int i, int j);
      return tri_holds(px, pz, out_x[i], out_z[i], in_x[i], in_z[i], in_x[j], in_z[j])
          || tri_holds(px, pz, out_x[i], out_z[i], in_x[j], in_z[j], out_x[j], out_z[j]);
    endfunction

    function locate_t locate(longint px, longint pz);
      int      n;
      bit      hit;
      locate_t r;
      n = eff_count();
      r.place = tspl_pkg::PLACE_W'(n - 1);
      hit = 1'b0;
      for (int i = 0; i + 1 < n; i++) begin
        if (seg_holds(px, pz, i, i + 1)) begin
          r.place = tspl_pkg::PLACE_W'(i);
          hit = 1'b1;
          break;
        end
      end
      // The closing segment only matters for the on-track flag.
      if (!hit) hit = seg_holds(px, pz, n - 1, 0);
      r.on_trk = hit;
      return r;
    endfunction

    function void note_item(track_cmd_t c);
      if (c.cmd == tspl_pkg::CMD_LOAD) begin
        in_x[c.idx] = c.ix;
        in_z[c.idx] = c.iz;
        out_x[c.idx] = c.ox;
        out_z[c.idx] = c.oz;
        loaded[c.idx] = 1'b1;
      end else begin
        pending.push_back(locate(c.qx, c.qz));
      end
    endfunction

    task check_result(logic [tspl_pkg::PLACE_W-1:0] place, logic on_trk);
      locate_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result place %0d on_track %0d with no query waiting",
                                  place, on_trk));
        return;
      end
      e = pending.pop_front();
      if (place !== e.place)
        report_mismatch($sformatf("place_index %0d, expected %0d", place, e.place));
      if (on_trk !== e.on_trk)
        report_mismatch($sformatf("on_track %0d, expected %0d (place %0d)",
                                  on_trk, e.on_trk, e.place));
    endtask

    task flush_check();
      while (pending.size() != 0) begin
        void'(pending.pop_front());
        report_mismatch("query result never arrived");
      end
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          cmd = tspl_pkg::CMD_LOAD;
  logic [tspl_pkg::INDEX_W-1:0]  entry_index = '0;
  logic signed [CW-1:0]          inner_x = '0, inner_z = '0, outer_x = '0, outer_z = '0;
  logic signed [CW-1:0]          query_x = '0, query_z = '0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [tspl_pkg::COUNT_W-1:0]  cfg_data = '0;
  logic                          result_valid;
  logic [tspl_pkg::PLACE_W-1:0]  place_index;
  logic                          on_track;

  track_scoreboard sb;
  int              items_sent = 0;
  int              idle_pct = 31;

  always #5 clk = ~clk;

  track_strip_point_locator uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .entry_index  (entry_index),
    .inner_x      (inner_x),
    .inner_z      (inner_z),
    .outer_x      (outer_x),
    .outer_z      (outer_z),
    .query_x      (query_x),
    .query_z      (query_z),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .place_index  (place_index),
    .on_track     (on_track)
  );

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) sb.check_result(place_index, on_track);
  end

  function automatic track_cmd_t make_load(int idx, int ix, int iz, int ox, int oz);
    track_cmd_t c;
    c.cmd = tspl_pkg::CMD_LOAD;
    c.idx = tspl_pkg::INDEX_W'(idx);
    c.ix = CW'(ix);
    c.iz = CW'(iz);
    c.ox = CW'(ox);
    c.oz = CW'(oz);
    c.qx = CW'($urandom);
    c.qz = CW'($urandom);
    return c;
  endfunction

  function automatic track_cmd_t make_query(int qx, int qz);
    track_cmd_t c;
    c.cmd = tspl_pkg::CMD_QUERY;
    c.idx = tspl_pkg::INDEX_W'($urandom);
    c.ix = CW'($urandom);
    c.iz = CW'($urandom);
    c.ox = CW'($urandom);
    c.oz = CW'($urandom);
    c.qx = CW'(qx);
    c.qz = CW'(qz);
    return c;
  endfunction

  function automatic int wobble(int j);
    return int'($urandom_range(0, 2 * j)) - j;
  endfunction

  // A point aimed inside, on an edge of, or at a corner of one triangle of a segment,
  // the closing segment included.
  function automatic track_cmd_t aim_query(int n);
    int     s, j;
    longint ax, az, bx, bz, cx, cz, wa, wb, wc;
    s = $urandom_range(0, n - 1);
    j = (s + 1 == n) ? 0 : s + 1;
    ax = sb.out_x[s];
    az = sb.out_z[s];
    if ($urandom_range(0, 1)) begin
      bx = sb.in_x[s];
      bz = sb.in_z[s];
      cx = sb.in_x[j];
      cz = sb.in_z[j];
    end else begin
      bx = sb.in_x[j];
      bz = sb.in_z[j];
      cx = sb.out_x[j];
      cz = sb.out_z[j];
    end
    wa = $urandom_range(0, 7);
    wb = $urandom_range(0, 7);
    wc = $urandom_range(0, 7);
    if (wa + wb + wc == 0) wa = 1;
    return make_query(int'((wa * ax + wb * bx + wc * cx) / (wa + wb + wc)),
                      int'((wa * az + wb * bz + wc * cz) / (wa + wb + wc)));
  endfunction

  task automatic send(input track_cmd_t c);
    start <= 1'b1;
    cmd <= c.cmd;
    entry_index <= c.idx;
    inner_x <= c.ix;
    inner_z <= c.iz;
    outer_x <= c.ox;
    outer_z <= c.oz;
    query_x <= c.qx;
    query_z <= c.qz;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(c);
    items_sent++;
  endtask

  // Start stays high into the next transaction unless the sender idles.
  task automatic issue(input track_cmd_t c);
    send(c);
    idle_pct = (items_sent < 650) ? 31 : ((items_sent < 1300) ? 51 : 0);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 12)) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(input logic [tspl_pkg::COUNT_W-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_count(v);
    cfg_valid <= 1'b0;
  endtask

  // A ring-shaped track so that each segment covers its own stretch.
  task automatic load_ring(input int n);
    real ang, ri, ro;
    int  cx, cz, jit;
    bit  flip;
    cx = int'($urandom_range(0, 12000)) - 6000;
    cz = int'($urandom_range(0, 12000)) - 6000;
    ri = $urandom_range(500, 12000);
    ro = ri + $urandom_range(200, 8000);
    jit = $urandom_range(0, 64);
    flip = 1'($urandom_range(0, 1));
    for (int i = 0; i < n; i++) begin
      ang = 6.283185307 * i / n;
      if (flip) ang = -ang;
      issue(make_load(i, cx + $rtoi(ri * $cos(ang)) + wobble(jit),
                      cz + $rtoi(ri * $sin(ang)) + wobble(jit),
                      cx + $rtoi(ro * $cos(ang)) + wobble(jit),
                      cz + $rtoi(ro * $sin(ang)) + wobble(jit)));
    end
  endtask

  // Arbitrary content, with some pairs collapsed onto one point.
  task automatic load_scatter(input int n);
    int ix, iz;
    for (int i = 0; i < n; i++) begin
      ix = $urandom;
      iz = $urandom;
      if ($urandom_range(0, 4) == 0) issue(make_load(i, ix, iz, ix, iz));
      else issue(make_load(i, ix, iz, $urandom, $urandom));
    end
  endtask

  task automatic fill_missing(input int n);
    for (int i = 0; i < n; i++) begin
      if (!sb.loaded[i]) issue(make_load(i, $urandom, $urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    int n, len, r, sess, v, guard;
    logic [tspl_pkg::COUNT_W-1:0] cnt;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset count of three.
    issue(make_load(0, 0, 0, -32768, -32768));
    issue(make_load(1, 100, 0, 32767, -32768));
    issue(make_load(2, 50, 100, 0, 32767));
    issue(make_query(-32768, -32768));
    issue(make_query(32767, 32767));
    issue(make_query(0, 0));
    issue(make_query(50, -16000));
    issue(make_query(0, 32767));
    issue(make_query(-20000, 10000));
    issue(make_query(32767, -32768));
    issue(make_query(-32768, 32767));
    issue(make_query(50, 50));
    // Collinear and collapsed pairs make triangles with no area.
    issue(make_load(1, 0, 0, 0, 0));
    issue(make_query(0, 0));
    issue(make_query(5, 5));
    issue(make_load(2, -1, -1, 1, 1));
    issue(make_query(7, 7));
    issue(make_query(7, 8));
    issue(make_query(-32768, -32768));
    issue(make_load(255, 32767, -32768, -32768, 32767));

    sess = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      case (sess)
        0: cnt = 9'd511;
        1: cnt = 9'd0;
        2: cnt = 9'd256;
        3: cnt = 9'd257;
        default: begin
          if ($urandom_range(0, 99) < 8) cnt = tspl_pkg::COUNT_W'($urandom_range(17, 511));
          else cnt = tspl_pkg::COUNT_W'($urandom_range(0, 16));
        end
      endcase
      write_count(cnt);
      n = sb.eff_count();
      if (sess == 0 || (n <= 64 && $urandom_range(0, 99) < 70)) begin
        if (sess == 0 || $urandom_range(0, 99) < 75) load_ring(n);
        else load_scatter(n);
      end
      fill_missing(n);
      // Long counts make slow queries, so those sessions stay short.
      len = (n > 64) ? 10 : $urandom_range(15, 40);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          issue(make_load($urandom_range(0, PTS - 1), $urandom, $urandom, $urandom, $urandom));
        end else if (r < 65) begin
          issue(aim_query(n));
        end else if (r < 85) begin
          v = $urandom_range(0, n - 1);
          issue(make_query(int'(sb.out_x[v]) + wobble(2000), int'(sb.in_z[v]) + wobble(2000)));
        end else begin
          issue(make_query($urandom, $urandom));
        end
        if ($urandom_range(0, 59) == 0) settle();
      end
      sess++;
    end

    start <= 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 6000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    sb.flush_check();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
